/* rtl/nra_pkg.sv */
// ----------------------------------------------------------------------------
// Normalized RMSE accumulator package
// Shared widths and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package nra_pkg;

  localparam int TRUTH_W  = 16;
  localparam int EST_W    = 19;
  localparam int RMSE_W   = 24;
  localparam int COUNT_W  = 21;
  localparam int SUM_W    = 53;
  localparam int WIDE_W   = 128;
  localparam int FRAC_BITS = 16;
  localparam logic [15:0] SCALE_SQ = 16'd65025;

  typedef struct packed {
    logic       load;
    logic       mul_ee;
    logic       mul_et;
    logic       mul_tt;
    logic       fin_start;
  } nra_cmd_t;

  typedef struct packed {
    logic       closes;
    logic       fin_done;
  } nra_stat_t;

endpackage

/* rtl/nra_if.sv */
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid/ready channel carrying one payload of parameterized type.
// ----------------------------------------------------------------------------
interface nra_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/nra_ctrl.sv */
// ----------------------------------------------------------------------------
// Accumulator controller
// Sequences the three products of a pair and the end-of-set computation.
// ----------------------------------------------------------------------------
module nra_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  nra_pkg::nra_stat_t stat,
  output nra_pkg::nra_cmd_t  cmd
);
  import nra_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EE   = 3'd1;
  localparam logic [2:0] S_ET   = 3'd2;
  localparam logic [2:0] S_TT   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EE;
        end
      end
      S_EE: begin
        cmd.mul_ee = 1'b1;
        state_next = S_ET;
      end
      S_ET: begin
        cmd.mul_et = 1'b1;
        state_next = S_TT;
      end
      S_TT: begin
        cmd.mul_tt = 1'b1;
        if (stat.closes) begin
          cmd.fin_start = 1'b1;
          state_next    = S_FIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (stat.fin_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end
endmodule

/* rtl/nra_finish.sv */
// ----------------------------------------------------------------------------
// End-of-set unit
// Forms the numerator with a shared 32x32 multiplier, divides by M^2 and by
// N one quotient bit per cycle, then takes the square root digit by digit.
// ----------------------------------------------------------------------------
module nra_finish (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nra_pkg::TRUTH_W-1:0]   peak,
  input  logic [nra_pkg::COUNT_W-1:0]   count,
  input  logic [nra_pkg::SUM_W-1:0]     s_ee,
  input  logic [nra_pkg::SUM_W-1:0]     s_et,
  input  logic [nra_pkg::SUM_W-1:0]     s_tt,
  output logic                          done,
  output logic [nra_pkg::RMSE_W-1:0]    result
);
  import nra_pkg::*;

  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_MA   = 4'd1;  // a = m2*see, 2 halves
  localparam logic [3:0] F_MB   = 4'd2;  // b = 2*m*2^F*set, both operands in 2 halves
  localparam logic [3:0] F_NUM  = 4'd3;
  localparam logic [3:0] F_SC   = 4'd4;  // times 65025, 4 chunks
  localparam logic [3:0] F_D1   = 4'd5;
  localparam logic [3:0] F_D2   = 4'd6;
  localparam logic [3:0] F_SQ   = 4'd7;
  localparam logic [3:0] F_DONE = 4'd8;

  logic [3:0]        fst;
  logic [6:0]        idx;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic [WIDE_W-1:0] acc, num, quo, rb, sbit;
  logic [63:0]       rem, dsor;
  logic [31:0]       m2;
  logic [47:0]       mb;
  logic [64:0]       rem_sh;
  logic [WIDE_W-1:0] trial;

  assign prod   = 64'(mul_a) * 64'(mul_b);
  assign rem_sh = {rem, num[WIDE_W-1]};
  assign trial  = rb + sbit;

  // Multiplier operand selection by step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (fst)
      F_MA: begin
        mul_a = m2;
        mul_b = idx[0] ? 32'(s_ee[SUM_W-1:32]) : s_ee[31:0];
      end
      F_MB: begin
        mul_a = 32'(mb[47:32]) ;
        mul_b = 32'(mb[31:0]);
        mul_a = idx[1] ? 32'(mb[47:32]) : mb[31:0];
        mul_b = idx[0] ? 32'(s_et[SUM_W-1:32]) : s_et[31:0];
      end
      F_SC: begin
        mul_a = 32'(SCALE_SQ);
        mul_b = num[idx[1:0]*32 +: 32];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fst  <= F_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (fst)
        F_IDLE: begin
          if (start) begin
            m2  <= 32'(peak) * 32'(peak);
            mb  <= {15'd0, peak, 17'd0};
            acc <= '0;
            idx <= '0;
            if (peak == '0) begin
              result <= '0;
              fst    <= F_DONE;
            end else begin
              fst <= F_MA;
            end
          end
        end
        F_MA: begin
          acc <= acc + (WIDE_W'(prod) << (idx[0] ? 32 : 0));
          idx <= idx + 7'd1;
          if (idx[0]) begin
            idx <= '0;
            num <= acc + (WIDE_W'(prod) << 32) + (WIDE_W'(s_tt) << (2 * FRAC_BITS));
            acc <= '0;
            fst <= F_MB;
          end
        end
        F_MB: begin
          acc <= acc + (WIDE_W'(prod) << (32 * (int'(idx[1]) + int'(idx[0]))));
          idx <= idx + 7'd1;
          if (idx[1:0] == 2'd3) fst <= F_NUM;
        end
        F_NUM: begin
          idx <= '0;
          acc <= '0;
          if (num < acc) begin
            result <= '0;
            fst    <= F_DONE;
          end else begin
            num <= num - acc;
            fst <= F_SC;
          end
        end
        F_SC: begin
          acc <= acc + (WIDE_W'(prod) << (32 * int'(idx[1:0])));
          idx <= idx + 7'd1;
          if (idx[1:0] == 2'd3) begin
            num  <= acc + (WIDE_W'(prod) << 96);
            idx  <= '0;
            rem  <= '0;
            quo  <= '0;
            dsor <= 64'(m2);
            fst  <= F_D1;
          end
        end
        F_D1, F_D2: begin
          num <= num << 1;
          if (rem_sh >= 65'(dsor)) begin
            rem <= 64'(rem_sh - 65'(dsor));
            quo <= {quo[WIDE_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            quo <= {quo[WIDE_W-2:0], 1'b0};
          end
          idx <= idx + 7'd1;
          if (idx == 7'd127) begin
            idx <= '0;
            rem <= '0;
            if (fst == F_D1) begin
              num  <= {quo[WIDE_W-2:0], rem_sh >= 65'(dsor)};
              dsor <= 64'(count);
              fst  <= F_D2;
            end else begin
              num  <= {quo[WIDE_W-2:0], rem_sh >= 65'(dsor)};
              rb   <= '0;
              sbit <= WIDE_W'(1) << 126;
              fst  <= F_SQ;
            end
          end
        end
        F_SQ: begin
          if (sbit == '0) begin
            result <= (rb > WIDE_W'(24'hFFFFFF)) ? 24'hFFFFFF : rb[RMSE_W-1:0];
            fst    <= F_DONE;
          end else begin
            if (num >= trial) begin
              num <= num - trial;
              rb  <= (rb >> 1) + sbit;
            end else begin
              rb <= rb >> 1;
            end
            sbit <= sbit >> 2;
          end
        end
        F_DONE: begin
          done <= 1'b1;
          fst  <= F_IDLE;
        end
        default: fst <= F_IDLE;
      endcase
    end
  end
endmodule

/* rtl/nra_datapath.sv */
// ----------------------------------------------------------------------------
// Accumulator datapath
// Clamps the estimate, keeps peak, count and the three sums through one
// shared multiplier, and holds the result for the output channel.
// ----------------------------------------------------------------------------
module nra_datapath #(
  parameter int MAX_ELEMENTS = 1048576
) (
  input  logic                        clk,
  input  logic                        rst,
  input  nra_pkg::nra_cmd_t           cmd,
  output nra_pkg::nra_stat_t          stat,
  input  logic [nra_pkg::TRUTH_W-1:0] truth_sample,
  input  logic signed [nra_pkg::EST_W-1:0] estimated_sample,
  input  logic                        last_element,
  input  logic                        out_take,
  output logic [nra_pkg::RMSE_W-1:0]  rmse_value,
  output logic                        truth_all_zero,
  output logic [nra_pkg::COUNT_W-1:0] element_total
);
  import nra_pkg::*;

  localparam logic [16:0] ONE = 17'd1 << FRAC_BITS;

  logic [TRUTH_W-1:0] t_r, peak;
  logic [16:0]        e_r;
  logic               last_r;
  logic [SUM_W-1:0]   s_ee, s_et, s_tt;
  logic [COUNT_W-1:0] cnt;
  logic [16:0]        op_a, op_b;
  logic [33:0]        prod;
  logic [16:0]        e_clamp;
  logic               fdone;
  logic [RMSE_W-1:0]  fres;

  assign e_clamp = estimated_sample[EST_W-1] ? 17'd0 :
                   ({1'b0, estimated_sample[EST_W-2:0]} > 19'(ONE)) ? ONE :
                   estimated_sample[16:0];

  always_comb begin
    op_a = 17'(t_r);
    op_b = 17'(t_r);
    if (cmd.mul_ee) begin
      op_a = e_r;
      op_b = e_r;
    end else if (cmd.mul_et) begin
      op_a = e_r;
    end
  end
  assign prod = op_a * op_b;

  assign stat.closes   = last_r || (32'(cnt) >= 32'(MAX_ELEMENTS));
  assign stat.fin_done = fdone;

  nra_finish u_finish (
    .clk(clk), .rst(rst), .start(cmd.fin_start), .peak(peak), .count(cnt),
    .s_ee(s_ee), .s_et(s_et), .s_tt(s_tt), .done(fdone), .result(fres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= '0; s_ee <= '0; s_et <= '0; s_tt <= '0; cnt <= '0;
    end else begin
      if (cmd.load) begin
        t_r    <= truth_sample;
        e_r    <= e_clamp;
        last_r <= last_element;
        if (truth_sample > peak) peak <= truth_sample;
        cnt <= cnt + COUNT_W'(1);
      end
      if (cmd.mul_ee) s_ee <= s_ee + SUM_W'(prod);
      if (cmd.mul_et) s_et <= s_et + SUM_W'(prod);
      if (cmd.mul_tt) s_tt <= s_tt + SUM_W'(prod);
      if (fdone) begin
        rmse_value     <= fres;
        truth_all_zero <= (peak == '0);
        element_total  <= cnt;
      end
      if (out_take) begin
        peak <= '0; s_ee <= '0; s_et <= '0; s_tt <= '0; cnt <= '0;
      end
    end
  end
endmodule

/* rtl/normalized_rmse_accumulator.sv */
// ----------------------------------------------------------------------------
// Normalized RMSE accumulator
// Channel  | dir | payload
// in_ch    | in  | truth_sample, estimated_sample, last_element
// out_ch   | out | rmse_value, truth_all_zero, element_total
// A pair is loaded, then its three products run in turn on the shared 17x17
// multiplier. Two 128-step restoring divisions and a 64-step square root
// dominate the closing pair's end-of-set work. rst is synchronous and clears
// all sums. No pair is taken while a result waits; a stalled result holds.
// ----------------------------------------------------------------------------
module normalized_rmse_accumulator #(
  parameter int MAX_ELEMENTS = 1048576
) (
  input logic clk,
  input logic rst,
  nra_if.sink   in_ch,
  nra_if.source out_ch
);
  import nra_pkg::*;

  nra_cmd_t  cmd;
  nra_stat_t stat;
  logic      tr_out;

  assign tr_out = out_ch.valid && out_ch.ready;

  nra_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .stat(stat), .cmd(cmd)
  );

  nra_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .truth_sample(in_ch.data.truth_sample),
    .estimated_sample(in_ch.data.estimated_sample),
    .last_element(in_ch.data.last_element), .out_take(tr_out),
    .rmse_value(out_ch.data.rmse_value), .truth_all_zero(out_ch.data.truth_all_zero),
    .element_total(out_ch.data.element_total)
  );

  // The input side and the output side never both transfer.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.valid && in_ch.ready && out_ch.valid)) else $error("in/out overlap");
  // A load is always followed by the first product step.
  a_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.mul_ee) else $error("missing product step");
endmodule
